>>> hdl/fidf_pkg.sv
// Shared types and constants for the FIR / direct-form-II IIR filter core.
// No dependencies; imported by every module under hdl/.
package fidf_pkg;

    localparam int SAMPLE_W   = 16;   // Q1.15 sample / state value
    localparam int COEF_W     = 18;   // Q3.15 coefficient
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int CMD_W      = 2;
    localparam int CI_W       = 4;    // coefficient index field
    localparam int TAP_CNT_W  = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int FRAC_W     = 15;

    localparam logic [TAP_CNT_W-1:0] TAP_COUNT_RST = 5'd16;
    localparam logic [SAMPLE_W-1:0]  SAT_MAX       = 16'h7FFF;
    localparam logic [SAMPLE_W-1:0]  SAT_MIN       = 16'h8000;
    localparam int                   ROUND_HALF    = 16384;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT   = 2'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_SAMPLE   = 2'd0,
        CMD_LOAD_FWD = 2'd1,
        CMD_LOAD_FB  = 2'd2,
        CMD_UNUSED   = 2'd3
    } cmd_t;

    // read issue from the sequencer to the storage
    typedef struct packed {
        logic issue;
        logic sel_fb;   // 1: feedback coefficients, 0: forward coefficients
    } rd_ctl_t;

    // coefficient write strobes
    typedef struct packed {
        logic fwd_en;
        logic fb_en;
    } coef_wr_t;

    // accumulator control
    typedef struct packed {
        logic acc_load;
        logic init_sample;  // load sample << 15 instead of zero
    } mac_ctl_t;

    // rounded and saturated accumulator
    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic                clip;
    } rs_t;

endpackage

>>> hdl/fidf_store.sv
// Delay line and coefficient memories with per-entry valid bits.
// Read data is registered; an entry never written reads as zero. Uses fidf_pkg.
module fidf_store
    import fidf_pkg::*;
#(
    parameter int MAX_TAPS = 16,
    parameter int IDX_W    = 4
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // delay line write
    input  logic                       dl_wr_en,
    input  logic [IDX_W-1:0]           dl_wr_addr,
    input  logic [SAMPLE_W-1:0]        dl_wr_data,
    // coefficient write
    input  coef_wr_t                   coef_wr,
    input  logic [IDX_W-1:0]           coef_wr_addr,
    input  logic [COEF_W-1:0]          coef_wr_data,
    // read
    input  rd_ctl_t                    rd_ctl,
    input  logic [IDX_W-1:0]           dl_rd_addr,
    input  logic [IDX_W-1:0]           coef_rd_addr,
    output logic                       rd_vld,
    output logic signed [SAMPLE_W-1:0] dl_q,
    output logic signed [COEF_W-1:0]   coef_q
);

    logic [SAMPLE_W-1:0] dl_mem  [MAX_TAPS];
    logic [COEF_W-1:0]   fwd_mem [MAX_TAPS];
    logic [COEF_W-1:0]   fb_mem  [MAX_TAPS];

    logic [MAX_TAPS-1:0] dl_ok_reg,  dl_ok_next;
    logic [MAX_TAPS-1:0] fwd_ok_reg, fwd_ok_next;
    logic [MAX_TAPS-1:0] fb_ok_reg,  fb_ok_next;

    logic [SAMPLE_W-1:0] dl_data_reg;
    logic [COEF_W-1:0]   fwd_data_reg, fb_data_reg;
    logic                dl_hit_reg, fwd_hit_reg, fb_hit_reg;
    logic                sel_fb_reg;
    logic                rd_vld_reg;

    always_comb begin
        dl_ok_next  = dl_ok_reg;
        fwd_ok_next = fwd_ok_reg;
        fb_ok_next  = fb_ok_reg;
        if (dl_wr_en) begin
            dl_ok_next[dl_wr_addr] = 1'b1;
        end
        if (coef_wr.fwd_en) begin
            fwd_ok_next[coef_wr_addr] = 1'b1;
        end
        if (coef_wr.fb_en) begin
            fb_ok_next[coef_wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dl_ok_reg  <= '0;
            fwd_ok_reg <= '0;
            fb_ok_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            dl_ok_reg  <= dl_ok_next;
            fwd_ok_reg <= fwd_ok_next;
            fb_ok_reg  <= fb_ok_next;
            rd_vld_reg <= rd_ctl.issue;
        end
    end

    // memory write ports
    always_ff @(posedge aclk) begin
        if (dl_wr_en) begin
            dl_mem[dl_wr_addr] <= dl_wr_data;
        end
        if (coef_wr.fwd_en) begin
            fwd_mem[coef_wr_addr] <= coef_wr_data;
        end
        if (coef_wr.fb_en) begin
            fb_mem[coef_wr_addr] <= coef_wr_data;
        end
    end

    // registered read ports
    always_ff @(posedge aclk) begin
        if (rd_ctl.issue) begin
            dl_data_reg  <= dl_mem[dl_rd_addr];
            fwd_data_reg <= fwd_mem[coef_rd_addr];
            fb_data_reg  <= fb_mem[coef_rd_addr];
            dl_hit_reg   <= dl_ok_reg[dl_rd_addr];
            fwd_hit_reg  <= fwd_ok_reg[coef_rd_addr];
            fb_hit_reg   <= fb_ok_reg[coef_rd_addr];
            sel_fb_reg   <= rd_ctl.sel_fb;
        end
    end

    assign rd_vld = rd_vld_reg;
    assign dl_q   = dl_hit_reg ? $signed(dl_data_reg) : '0;

    always_comb begin
        if (sel_fb_reg) begin
            coef_q = fb_hit_reg ? $signed(fb_data_reg) : '0;
        end else begin
            coef_q = fwd_hit_reg ? $signed(fwd_data_reg) : '0;
        end
    end

endmodule

>>> hdl/fidf_mac.sv
// Shared multiply-accumulate unit with Q1.15 round-half-up and saturation.
// Product is registered before the accumulator. Uses fidf_pkg.
module fidf_mac
    import fidf_pkg::*;
#(
    parameter int ACC_W = 39
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  mac_ctl_t                   ctl,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic                       rd_vld,
    input  logic signed [SAMPLE_W-1:0] dl_data,
    input  logic signed [COEF_W-1:0]   coef_data,
    output rs_t                        rs
);

    localparam int QW = ACC_W - FRAC_W;

    logic signed [PROD_W-1:0] prod_full;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_vld_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [ACC_W-1:0]  rnd;
    logic        [QW-1:0]     q;
    logic                     hi, lo;

    assign prod_full = dl_data * coef_data;

    always_comb begin
        acc_next = acc_reg;
        if (ctl.acc_load) begin
            acc_next = ctl.init_sample ? (ACC_W'(sample) <<< FRAC_W) : '0;
        end else if (prod_vld_reg) begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
        end else begin
            prod_vld_reg <= rd_vld;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_full;
        acc_reg  <= acc_next;
    end

    // floor((acc + 2^14) / 2^15), then clip to 16 bits
    assign rnd = acc_reg + ACC_W'(ROUND_HALF);
    assign q   = rnd[ACC_W-1:FRAC_W];
    assign hi  = !q[QW-1] && (|q[QW-2:SAMPLE_W-1]);
    assign lo  = q[QW-1] && !(&q[QW-2:SAMPLE_W-1]);

    always_comb begin
        rs.clip = hi || lo;
        if (hi) begin
            rs.value = SAT_MAX;
        end else if (lo) begin
            rs.value = SAT_MIN;
        end else begin
            rs.value = q[SAMPLE_W-1:0];
        end
    end

endmodule

>>> hdl/fir_iir_direct_form2_filter_core.sv
// FIR / direct-form-II IIR filter core: sequencer, storage and shared MAC.
// Coefficient loads go straight to memory and give no result beat. A sample
// runs the feedback taps (IIR mode only), writes the state value and runs the
// forward taps; a stale write position at or past L (L = taps in use) is first
// reduced modulo L. One sample in flight, one MAC tap per cycle: no new beat
// is taken until the result is loaded into the output register. Sync active-low reset.
module fir_iir_direct_form2_filter_core
    import fidf_pkg::*;
#(
    parameter int MAX_TAPS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // sample / coefficient input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [39:0]           s_tdata,   // sample_in[15:0], coef_index[19:16],
                                             // coef_value[37:20], zero pad
    input  logic [CMD_W-1:0]      s_tuser,   // command[1:0]
    // filtered output
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // sample_out[15:0]
    output logic                  m_tuser,   // saturated[0]
    // configuration write
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int LEN_W = $clog2(MAX_TAPS + 1);
    localparam int ACC_W = PROD_W + $clog2(MAX_TAPS) + 1;
    localparam int CMP_W = (LEN_W > TAP_CNT_W) ? LEN_W : TAP_CNT_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRAP,      // reduce write position modulo L
        ST_FB_RUN,    // feedback taps through the MAC
        ST_FB_DRAIN,
        ST_WRITE,     // store the state value
        ST_FF_RUN,    // forward taps through the MAC
        ST_FF_DRAIN,
        ST_DONE       // load output register
    } state_t;

    // input field unpacking
    logic signed [SAMPLE_W-1:0] in_sample;
    logic [CI_W-1:0]            in_coef_index;
    logic [COEF_W-1:0]          in_coef_value;
    cmd_t                       in_cmd;

    assign in_sample     = $signed(s_tdata[15:0]);
    assign in_coef_index = s_tdata[19:16];
    assign in_coef_value = s_tdata[37:20];
    assign in_cmd        = cmd_t'(s_tuser);

    // configuration
    logic                 mode_reg;
    logic [TAP_CNT_W-1:0] tap_count_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= 1'b0;
            tap_count_reg <= TAP_COUNT_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_FILTER_MODE: mode_reg      <= cfg_data[0];
                CFG_TAP_COUNT:   tap_count_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // tap count clamped to [1, MAX_TAPS]
    logic [CMP_W-1:0] tc_ext;
    logic [LEN_W-1:0] len_clamped;

    assign tc_ext = CMP_W'(tap_count_reg);

    always_comb begin
        if (tc_ext == '0) begin
            len_clamped = LEN_W'(1);
        end else if (tc_ext > CMP_W'(MAX_TAPS)) begin
            len_clamped = LEN_W'(MAX_TAPS);
        end else begin
            len_clamped = LEN_W'(tc_ext);
        end
    end

    // sequencer state
    state_t                     state_reg, state_next;
    logic [IDX_W-1:0]           wp_reg, wp_next;
    logic [IDX_W-1:0]           pos_reg, pos_next;
    logic [IDX_W-1:0]           idx_reg, idx_next;
    logic [IDX_W-1:0]           n_reg, n_next;
    logic [LEN_W-1:0]           len_reg, len_next;
    logic                       drain_reg, drain_next;
    logic signed [SAMPLE_W-1:0] sample_reg, sample_next;
    logic                       sat_reg, sat_next;
    logic                       m_tvalid_reg, m_tvalid_next;
    logic [SAMPLE_W-1:0]        m_data_reg, m_data_next;
    logic                       m_sat_reg, m_sat_next;

    // datapath controls
    rd_ctl_t             rd_ctl;
    mac_ctl_t            mac_ctl;
    coef_wr_t            coef_wr;
    logic                dl_wr_en;
    logic [SAMPLE_W-1:0] dl_wr_data;
    logic                rd_vld;
    logic signed [SAMPLE_W-1:0] dl_q;
    logic signed [COEF_W-1:0]   coef_q;
    rs_t                 rs;

    logic                s_beat;
    logic                ci_in_range;
    logic [IDX_W-1:0]    pos_inc;     // (pos + 1) mod L
    logic [IDX_W-1:0]    idx_dec;     // (idx - 1) mod L
    logic                last_tap;
    logic                out_free;

    assign s_tready    = (state_reg == ST_IDLE);
    assign s_beat      = s_tvalid && s_tready;
    assign ci_in_range = (int'(in_coef_index) < MAX_TAPS);
    assign pos_inc     = ((LEN_W'(pos_reg) + LEN_W'(1)) == len_reg) ? '0 : pos_reg + 1'b1;
    assign idx_dec     = (idx_reg == '0) ? IDX_W'(len_reg - LEN_W'(1)) : idx_reg - 1'b1;
    assign last_tap    = (LEN_W'(n_reg) == (len_reg - LEN_W'(1)));
    assign out_free    = !m_tvalid_reg || m_tready;

    // coefficient loads go straight to memory from the input beat
    always_comb begin
        coef_wr.fwd_en = s_beat && (in_cmd == CMD_LOAD_FWD) && ci_in_range;
        coef_wr.fb_en  = s_beat && (in_cmd == CMD_LOAD_FB) && ci_in_range;
    end

    always_comb begin
        state_next    = state_reg;
        wp_next       = wp_reg;
        pos_next      = pos_reg;
        idx_next      = idx_reg;
        n_next        = n_reg;
        len_next      = len_reg;
        drain_next    = drain_reg;
        sample_next   = sample_reg;
        sat_next      = sat_reg;
        m_tvalid_next = m_tvalid_reg;
        m_data_next   = m_data_reg;
        m_sat_next    = m_sat_reg;

        rd_ctl          = '0;
        mac_ctl         = '0;
        dl_wr_en        = 1'b0;
        dl_wr_data      = sample_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_beat && (in_cmd == CMD_SAMPLE)) begin
                    sample_next = in_sample;
                    pos_next    = wp_reg;
                    len_next    = len_clamped;
                    sat_next    = 1'b0;
                    state_next  = ST_WRAP;
                end
            end
            ST_WRAP: begin
                if (LEN_W'(pos_reg) >= len_reg) begin
                    pos_next = IDX_W'(LEN_W'(pos_reg) - len_reg);
                end else begin
                    n_next = '0;
                    if (mode_reg) begin
                        // feedback walk starts one slot past the write position
                        idx_next            = pos_inc;
                        mac_ctl.acc_load    = 1'b1;
                        mac_ctl.init_sample = 1'b1;
                        state_next          = ST_FB_RUN;
                    end else begin
                        state_next = ST_WRITE;
                    end
                end
            end
            ST_FB_RUN: begin
                rd_ctl.issue  = 1'b1;
                rd_ctl.sel_fb = 1'b1;
                n_next        = n_reg + 1'b1;
                idx_next      = idx_dec;
                if (last_tap) begin
                    drain_next = 1'b1;
                    state_next = ST_FB_DRAIN;
                end
            end
            ST_FB_DRAIN: begin
                drain_next = 1'b0;
                if (!drain_reg) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                dl_wr_en = 1'b1;
                if (mode_reg) begin
                    dl_wr_data = rs.value;
                    sat_next   = rs.clip;
                end
                idx_next         = pos_reg;
                n_next           = '0;
                mac_ctl.acc_load = 1'b1;
                state_next       = ST_FF_RUN;
            end
            ST_FF_RUN: begin
                rd_ctl.issue = 1'b1;
                n_next       = n_reg + 1'b1;
                idx_next     = idx_dec;
                if (last_tap) begin
                    drain_next = 1'b1;
                    state_next = ST_FF_DRAIN;
                end
            end
            ST_FF_DRAIN: begin
                drain_next = 1'b0;
                if (!drain_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold here while the previous result beat is still pending
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = rs.value;
                    m_sat_next    = sat_reg || rs.clip;
                    wp_next       = pos_inc;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            wp_reg       <= '0;
            m_tvalid_reg <= 1'b0;
            drain_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            wp_reg       <= wp_next;
            m_tvalid_reg <= m_tvalid_next;
            drain_reg    <= drain_next;
        end
        pos_reg    <= pos_next;
        idx_reg    <= idx_next;
        n_reg      <= n_next;
        len_reg    <= len_next;
        sample_reg <= sample_next;
        sat_reg    <= sat_next;
        m_data_reg <= m_data_next;
        m_sat_reg  <= m_sat_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_sat_reg;

    fidf_store #(
        .MAX_TAPS (MAX_TAPS),
        .IDX_W    (IDX_W)
    ) u_store (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .dl_wr_en     (dl_wr_en),
        .dl_wr_addr   (pos_reg),
        .dl_wr_data   (dl_wr_data),
        .coef_wr      (coef_wr),
        .coef_wr_addr (IDX_W'(in_coef_index)),
        .coef_wr_data (in_coef_value),
        .rd_ctl       (rd_ctl),
        .dl_rd_addr   (idx_reg),
        .coef_rd_addr (n_reg),
        .rd_vld       (rd_vld),
        .dl_q         (dl_q),
        .coef_q       (coef_q)
    );

    fidf_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (mac_ctl),
        .sample    (sample_reg),
        .rd_vld    (rd_vld),
        .dl_data   (dl_q),
        .coef_data (coef_q),
        .rs        (rs)
    );

endmodule

>>> bench/filter_checker.sv
`timescale 1ns / 1ps
// Checker for the FIR / direct-form-II IIR filter core: mirrors the filter
// state from the observed beats, predicts each result and compares it.
// Depends on fidf_pkg for field widths, commands and register indexes.
module filter_checker
    import fidf_pkg::*;
#(
    parameter int MAX_TAPS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [39:0]           s_tdata,
    input  logic [CMD_W-1:0]      s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [15:0]           m_tdata,
    input  logic                  m_tuser,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending
);

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_out;
        logic                saturated;
    } filter_result_t;

    // mirrored filter state
    logic signed [SAMPLE_W-1:0] dline    [MAX_TAPS];
    logic signed [COEF_W-1:0]   fwd_coef [MAX_TAPS];
    logic signed [COEF_W-1:0]   fb_coef  [MAX_TAPS];
    int                         wr_pos;
    logic                       iir_mode;
    logic [TAP_CNT_W-1:0]       taps_cfg;

    filter_result_t expected_outputs[$];
    int             fails;

    initial begin
        fails = 0;
    end

    // Q.30 -> Q1.15, round half up, saturate
    function automatic logic [SAMPLE_W-1:0] round_q15(input longint acc, inout logic clip);
        longint q;
        q = (acc + ROUND_HALF) >>> FRAC_W;
        if (q > 32767) begin
            clip = 1'b1;
            return SAT_MAX;
        end
        if (q < -32768) begin
            clip = 1'b1;
            return SAT_MIN;
        end
        return q[SAMPLE_W-1:0];
    endfunction

    // walks the delay line backwards from start, coefficient n against slot start-n
    function automatic longint tap_sum(input logic use_fb, input int start, input int len);
        longint acc;
        int     idx;
        acc = 0;
        idx = start % len;
        for (int n = 0; n < len; n++) begin
            acc += (use_fb ? longint'(fb_coef[n]) : longint'(fwd_coef[n]))
                   * longint'(dline[idx]);
            idx = (idx == 0) ? len - 1 : idx - 1;
        end
        return acc;
    endfunction

    function automatic filter_result_t run_sample(input logic signed [SAMPLE_W-1:0] x);
        filter_result_t res;
        int             len;
        int             pos;
        longint         acc;
        logic           clip;
        clip = 1'b0;
        len  = int'(taps_cfg);
        if (len < 1)
            len = 1;
        if (len > MAX_TAPS)
            len = MAX_TAPS;
        pos = wr_pos % len;
        if (iir_mode) begin
            acc = (longint'(x) <<< FRAC_W) + tap_sum(1'b1, (pos + 1) % len, len);
            dline[pos] = round_q15(acc, clip);
        end else begin
            dline[pos] = x;
        end
        res.sample_out = round_q15(tap_sum(1'b0, pos, len), clip);
        res.saturated  = clip;
        wr_pos = (pos + 1) % len;
        return res;
    endfunction

    always @(posedge aclk) begin
        filter_result_t exp_res;
        if (!aresetn) begin
            for (int i = 0; i < MAX_TAPS; i++) begin
                dline[i]    = '0;
                fwd_coef[i] = '0;
                fb_coef[i]  = '0;
            end
            wr_pos   = 0;
            iir_mode = 1'b0;
            taps_cfg = TAP_COUNT_RST;
            expected_outputs.delete();
        end else begin
            // results first, so a beat can never match an item accepted this edge
            if (m_tvalid && m_tready) begin
                if (expected_outputs.size() == 0) begin
                    $error("unexpected result beat: sample_out %0d, saturated %0d",
                           $signed(m_tdata), m_tuser);
                    fails++;
                end else begin
                    exp_res = expected_outputs.pop_front();
                    if (m_tdata !== exp_res.sample_out) begin
                        $error("sample_out: expected %0d, got %0d",
                               $signed(exp_res.sample_out), $signed(m_tdata));
                        fails++;
                    end
                    if (m_tuser !== exp_res.saturated) begin
                        $error("saturated: expected %0d, got %0d",
                               exp_res.saturated, m_tuser);
                        fails++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_FILTER_MODE: iir_mode = cfg_data[0];
                    CFG_TAP_COUNT:   taps_cfg = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                case (cmd_t'(s_tuser))
                    CMD_SAMPLE:   expected_outputs.push_back(run_sample(s_tdata[15:0]));
                    CMD_LOAD_FWD: fwd_coef[s_tdata[19:16]] = s_tdata[37:20];
                    CMD_LOAD_FB:  fb_coef[s_tdata[19:16]]  = s_tdata[37:20];
                    default: ;
                endcase
            end
        end
        fail_count <= fails;
        pending    <= expected_outputs.size();
    end

endmodule

>>> bench/tb_fir_iir_direct_form2_filter_core.sv
`timescale 1ns / 1ps
// Testbench top for the FIR / direct-form-II IIR filter core: clock, reset,
// stimulus and verdict. Depends on fidf_pkg and bench/filter_checker.sv.
module tb_fir_iir_direct_form2_filter_core;
    import fidf_pkg::*;

    localparam int MAX_TAPS = 16;
    // index with no register behind it; the core must ignore the write
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
    // settle time before a register write or the verdict; it covers the slowest
    // sample, the folding of a stale write position included
    localparam int SETTLE_CYCLES = 70;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 75;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [39:0]           s_tdata   = '0;   // sample_in[15:0], coef_index[19:16],
                                             // coef_value[37:20], zero pad
    logic [CMD_W-1:0]      s_tuser   = '0;   // command[1:0]
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [15:0]           m_tdata;          // sample_out[15:0]
    logic                  m_tuser;          // saturated[0]
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int   fail_count;
    int   pending;
    logic quiet_phase = 1'b0;   // no sender gaps while set

    always #5 aclk = ~aclk;

    fir_iir_direct_form2_filter_core #(
        .MAX_TAPS (MAX_TAPS)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    filter_checker #(
        .MAX_TAPS (MAX_TAPS)
    ) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Mostly back-to-back, some short gaps, a few long ones.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_phase || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Mostly modest coefficients so IIR runs stay mostly in range; now and
    // then a full-width one to hit every bit and force saturation.
    function automatic logic [COEF_W-1:0] rand_coef(input int mag);
        if ($urandom_range(0, 9) == 0)
            return COEF_W'($urandom);
        return COEF_W'(int'($urandom_range(0, 2 * mag)) - mag);
    endfunction

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 19))
            0:       return SAT_MAX;
            1:       return SAT_MIN;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // One input beat. valid stays high if the next beat follows with no gap;
    // it only drops in a step where nothing raises it.
    task automatic send_beat(input cmd_t cmd, input logic [SAMPLE_W-1:0] smp,
                             input logic [CI_W-1:0] ci, input logic [COEF_W-1:0] cv);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, cv, ci, smp};
        do @(posedge aclk); while (!s_tready);
        gap = gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // unused fields carry noise; the core has to ignore them
    task automatic put_sample(input logic [SAMPLE_W-1:0] smp);
        send_beat(CMD_SAMPLE, smp, CI_W'($urandom), COEF_W'($urandom));
    endtask

    task automatic put_coef(input cmd_t cmd, input logic [CI_W-1:0] ci,
                            input logic [COEF_W-1:0] cv);
        send_beat(cmd, SAMPLE_W'($urandom), ci, cv);
    endtask

    // Drop valid, wait for every expected result, then let the core settle.
    // pending is registered in the checker, so the first look comes only once it has been updated.
    task automatic wait_drained(input int settle);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    // Register writes only land while the core is idle.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        wait_drained(SETTLE_CYCLES);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Result side: runs of ready with stalls between, plus long stall-free runs.
    initial begin
        int run;
        int stall;
        forever begin
            run   = ($urandom_range(0, 9) == 0) ? $urandom_range(150, 400)
                                                : $urandom_range(1, 12);
            stall = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                : $urandom_range(0, 3);
            m_tready <= 1'b1;
            repeat (run) @(posedge aclk);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    initial begin
        int phase_taps[PHASES];
        int len;
        int taps;
        int r;

        phase_taps = '{1, 16, 0, 31, 3, 8, 16, 5};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // ---- directed: reset config is FIR, 16 taps ----
        put_coef(CMD_LOAD_FWD, 4'd0, 18'h1FFFF);     // largest positive coefficient
        put_coef(CMD_LOAD_FWD, 4'd1, 18'h20000);     // most negative coefficient
        put_coef(CMD_LOAD_FWD, 4'd15, 18'h08000);    // 1.0 on the oldest tap
        put_coef(CMD_LOAD_FB, 4'd15, 18'h20000);
        put_coef(CMD_LOAD_FB, 4'd0, 18'h1FFFF);
        send_beat(CMD_UNUSED, 16'hFFFF, 4'hF, 18'h3FFFF);   // must vanish
        put_sample(SAT_MAX);                         // x4 gain: clips high
        put_sample(SAT_MIN);
        put_sample(16'h0000);
        put_sample(16'hFFFF);
        put_sample(16'h0001);

        // IIR, 2 taps: write position 5 gets folded, feedback walk wraps to slot 0
        write_register(CFG_FILTER_MODE, 5'd1);
        write_register(CFG_TAP_COUNT, 5'd2);
        put_sample(SAT_MAX);                         // state value clips too
        put_sample(SAT_MIN);
        put_sample(16'h1234);
        put_sample(16'hFFFF);

        // tap count 0 acts as a single tap
        write_register(CFG_TAP_COUNT, 5'd0);
        put_sample(16'h4000);
        put_sample(16'hC000);

        // above the maximum clamps to 16; mode takes only bit 0; stray index ignored
        write_register(CFG_TAP_COUNT, 5'd31);
        write_register(CFG_FILTER_MODE, 5'b11110);
        write_register(CFG_UNMAPPED, 5'h1F);
        put_sample(SAT_MAX);
        put_coef(CMD_LOAD_FWD, 4'd7, 18'h00000);
        put_sample(16'h0000);

        // ---- random phases ----
        for (int p = 0; p < PHASES; p++) begin
            taps = (p == PHASES - 1) ? $urandom_range(0, 31) : phase_taps[p];
            write_register(CFG_FILTER_MODE, CFG_DATA_W'({$urandom_range(0, 15), p[0]}));
            write_register(CFG_TAP_COUNT, CFG_DATA_W'(taps));
            quiet_phase = (p == 2 || p == 5);
            len = (taps < 1) ? 1 : (taps > MAX_TAPS) ? MAX_TAPS : taps;

            // fresh coefficient set for the taps in use; feedback scaled by L
            for (int i = 0; i < len; i++) begin
                put_coef(CMD_LOAD_FWD, CI_W'(i), rand_coef(16384));
                put_coef(CMD_LOAD_FB, CI_W'(i), rand_coef(32768 / len));
            end

            for (int k = 2 * len; k < PHASE_ITEMS; k++) begin
                r = $urandom_range(0, 99);
                if (r < 75)
                    put_sample(rand_sample());
                else if (r < 85)
                    put_coef(CMD_LOAD_FWD, CI_W'($urandom), rand_coef(16384));
                else if (r < 93)
                    put_coef(CMD_LOAD_FB, CI_W'($urandom), rand_coef(32768 / len));
                else
                    send_beat(CMD_UNUSED, SAMPLE_W'($urandom), CI_W'($urandom),
                              COEF_W'($urandom));
            end
        end
        quiet_phase = 1'b0;

        wait_drained(SETTLE_CYCLES);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // hard stop, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
